// ===== sv/u8u16_pkg.sv =====
package u8u16_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_ILLEGAL   = 2'd2
  } dec_status_t;

  // One entry of the result queue
  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_unit;
    dec_status_t status;
    logic        stream_end;
  } result_t;

  // Outcome of decoding one complete sequence
  typedef struct packed {
    logic        bad;
    logic        pair;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } dec_res_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Offsets removed after shifting in lead and trailing bytes (by trail count)
  localparam logic [31:0] SEQ_OFFSET [4] = '{
    32'h0000_0000, 32'h0000_3080, 32'h000E_2080, 32'h03C8_2080
  };

  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [15:0] REPLACEMENT  = 16'hFFFD;
  localparam logic [31:0] PLANE1_BASE  = 32'h0001_0000;
  localparam logic [31:0] MAX_CODE     = 32'h0010_FFFF;
  localparam logic [7:0]  LEAD_MAX     = 8'hF4;
  localparam logic [7:0]  LEAD_MIN2    = 8'hC2;

  function automatic logic [2:0] trail_count(input logic [7:0] b);
    logic [2:0] n;
    if (b < 8'hC0)      n = 3'd0;
    else if (b < 8'hE0) n = 3'd1;
    else if (b < 8'hF0) n = 3'd2;
    else if (b < 8'hF8) n = 3'd3;
    else if (b < 8'hFC) n = 3'd4;
    else                n = 3'd5;
    return n;
  endfunction

endpackage

// ===== sv/u8u16_seq_dec.sv =====
module u8u16_seq_dec
  import u8u16_pkg::*;
(
  input  logic [7:0]      lead,
  input  logic [2:0][7:0] trail,
  input  logic [2:0]      need,
  input  logic            lenient,
  output dec_res_t        res
);

  logic        legal;
  logic [31:0] acc;
  logic [31:0] ch;
  logic [31:0] ch_sup;
  logic        surr;

  // Legality of the whole sequence
  always_comb begin
    legal = 1'b1;
    if (need > 3'd3) legal = 1'b0;
    if (need >= 3'd1) begin
      if (need == 3'd3 && !(trail[2] inside {[8'h80:8'hBF]})) legal = 1'b0;
      if (need >= 3'd2 && !(trail[1] inside {[8'h80:8'hBF]})) legal = 1'b0;
      if (trail[0] > 8'hBF) legal = 1'b0;
      case (lead)
        8'hE0:    if (trail[0] < 8'hA0) legal = 1'b0;
        8'hED:    if (trail[0] > 8'h9F) legal = 1'b0;
        8'hF0:    if (trail[0] < 8'h90) legal = 1'b0;
        LEAD_MAX: if (trail[0] > 8'h8F) legal = 1'b0;
        default:  if (trail[0] < 8'h80) legal = 1'b0;
      endcase
    end
    if (lead >= 8'h80 && lead < LEAD_MIN2) legal = 1'b0;
    if (lead > LEAD_MAX) legal = 1'b0;
  end

  always_comb begin
    acc = {24'd0, lead};
    if (need >= 3'd1) acc = (acc << 6) + {24'd0, trail[0]};
    if (need >= 3'd2) acc = (acc << 6) + {24'd0, trail[1]};
    if (need >= 3'd3) acc = (acc << 6) + {24'd0, trail[2]};
    ch     = acc - SEQ_OFFSET[need[1:0]];
    ch_sup = ch - PLANE1_BASE;
    surr   = (ch >= 32'h0000_D800) && (ch <= 32'h0000_DFFF);
  end

  always_comb begin
    res       = '0;
    res.unit0 = ch[15:0];
    res.unit1 = ch_sup[15:0];
    if (!legal) begin
      res.bad = 1'b1;
    end else if (ch <= 32'h0000_FFFF) begin
      if (surr) begin
        res.bad   = !lenient;
        res.unit0 = REPLACEMENT;
      end
    end else if (ch > MAX_CODE) begin
      res.bad   = !lenient;
      res.unit0 = REPLACEMENT;
    end else begin
      res.pair  = 1'b1;
      res.unit0 = ch_sup[25:10] + HI_SURR_BASE;
      res.unit1 = {6'd0, ch_sup[9:0]} + LO_SURR_BASE;
    end
  end

endmodule

// ===== sv/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 stream decoder.
// Input channel (in_valid/in_ready): one source byte per transfer, with
// in_stream_last on the final byte of a stream. Result channel
// (out_valid/out_ready): one UTF-16 unit or one status result per transfer.
// A legal sequence gives one unit, or a surrogate pair as two transfers.
// An incomplete stream gives status exhausted, an illegal sequence status
// illegal; both carry out_stream_end, and after an error the following bytes
// are dropped up to and including the next end-marked byte.
// A byte that completes a sequence is decoded from the input register, and
// its results are written into the result queue, whose head drives the output.
// Throughput: one byte per cycle while the result queue has room; the single
// result port sends a surrogate pair as two transfers. Bytes pass an input register and
// are decoded into a four-entry result queue, which lets intake continue
// while a result waits for the receiver; when out_ready stays low the queue
// fills and in_ready drops. cfg_we writes lenient mode from cfg_wdata.
// Reset: the queue empties, no sequence is open, lenient mode is set.
module utf8_to_utf16_decoder
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_stream_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_has_unit,
  output logic [1:0]  out_status,
  output logic        out_stream_end
);

  logic            lenient_r;
  logic            s1_vld_r;
  logic [7:0]      s1_byte_r;
  logic            s1_last_r;

  logic [7:0]      lead_r, lead_nxt;
  logic [2:0][7:0] trail_r, trail_nxt;
  logic [2:0]      need_r, need_nxt;
  logic [2:0]      seen_r, seen_nxt;
  logic            disc_r, disc_nxt;

  result_t         q_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QAW:0]    cnt_r;

  logic            pop, s1_fire;
  logic [1:0]      n_push;
  result_t         res0, res1;
  logic [2:0]      eff_need;
  logic            complete;
  dec_res_t        dec;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign s1_fire   = s1_vld_r && ((cnt_r <= (QAW+1)'(QDEPTH - 2))
                     || (cnt_r == (QAW+1)'(QDEPTH - 1) && pop));
  assign in_ready  = !s1_vld_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lenient_r <= 1'b1;
    end else if (cfg_we) begin
      lenient_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_stream_last;
    end
  end

  // Sequence collection: merge the current byte into the stored sequence
  always_comb begin
    lead_nxt  = lead_r;
    trail_nxt = trail_r;
    seen_nxt  = seen_r;
    if (need_r == 3'd0) begin
      lead_nxt = s1_byte_r;
      seen_nxt = 3'd0;
      eff_need = trail_count(s1_byte_r);
    end else begin
      if (seen_r < 3'd3) trail_nxt[seen_r[1:0]] = s1_byte_r;
      seen_nxt = seen_r + 3'd1;
      eff_need = need_r;
    end
    complete = (seen_nxt >= eff_need);
  end

  u8u16_seq_dec u_dec (
    .lead    (lead_nxt),
    .trail   (trail_nxt),
    .need    (eff_need),
    .lenient (lenient_r),
    .res     (dec)
  );

  always_comb begin
    need_nxt = need_r;
    disc_nxt = disc_r;
    n_push   = 2'd0;
    res0     = '0;
    res1     = '0;
    if (disc_r) begin
      if (s1_last_r) disc_nxt = 1'b0;
    end else if (!complete) begin
      need_nxt = eff_need;
      if (s1_last_r) begin
        need_nxt        = 3'd0;
        n_push          = 2'd1;
        res0.status     = ST_EXHAUSTED;
        res0.stream_end = 1'b1;
      end
    end else begin
      need_nxt = 3'd0;
      if (dec.bad) begin
        n_push          = 2'd1;
        res0.status     = ST_ILLEGAL;
        res0.stream_end = 1'b1;
        disc_nxt        = !s1_last_r;
      end else begin
        res0.code_unit = dec.unit0;
        res0.has_unit  = 1'b1;
        res0.status    = ST_OK;
        if (dec.pair) begin
          n_push          = 2'd2;
          res1.code_unit  = dec.unit1;
          res1.has_unit   = 1'b1;
          res1.status     = ST_OK;
          res1.stream_end = s1_last_r;
        end else begin
          n_push          = 2'd1;
          res0.stream_end = s1_last_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
      need_r <= '0;
      seen_r <= '0;
      disc_r <= 1'b0;
    end else if (s1_fire) begin
      lead_r <= lead_nxt;
      need_r <= need_nxt;
      seen_r <= need_nxt == 3'd0 ? 3'd0 : seen_nxt;
      disc_r <= disc_nxt;
    end
  end

  // Trailing byte store has no reset: only entries written this sequence are read
  always_ff @(posedge clk) begin
    if (s1_fire && !disc_r) begin
      trail_r <= trail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && n_push != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
      if (n_push == 2'd2) q_r[wr_ptr_r + QAW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (s1_fire) wr_ptr_r <= wr_ptr_r + QAW'(n_push);
      if (pop)     rd_ptr_r <= rd_ptr_r + QAW'(1);
      cnt_r <= cnt_r + (s1_fire ? (QAW+1)'(n_push) : '0) - (QAW+1)'(pop);
    end
  end

  assign out_code_unit  = q_r[rd_ptr_r].code_unit;
  assign out_has_unit   = q_r[rd_ptr_r].has_unit;
  assign out_status     = q_r[rd_ptr_r].status;
  assign out_stream_end = q_r[rd_ptr_r].stream_end;

endmodule

// ===== sv/u8u16_checker.sv =====
module u8u16_checker
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_code_unit,
  input  logic        out_has_unit,
  input  logic [1:0]  out_status,
  input  logic        out_stream_end
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_unit)
      && $stable(out_has_unit) && $stable(out_status) && $stable(out_stream_end))
    else $error("result changed while stalled");

  // A unit only comes with status ok
  a_unit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_unit |-> out_status == ST_OK)
    else $error("unit with error status");

  // Error results end the stream and carry no unit
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_stream_end && !out_has_unit
      && out_code_unit == 16'd0)
    else $error("malformed error result");

  // Every result either carries a unit or reports an error
  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_unit |->
      out_status == ST_EXHAUSTED || out_status == ST_ILLEGAL)
    else $error("empty ok result");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_chk (.*);
